// ----- hdl/tebs_pkg.sv -----
// Package for the timed event block splitter: action and result codes, states, config registers.
// No dependencies.
`timescale 1ns / 1ps
package tebs_pkg;
	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_CLEAR  = 3'd1,
		ACT_RENDER = 3'd2,
		ACT_NOW    = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_SEG   = 2'd0,
		KIND_DISP  = 2'd1,
		KIND_REPLY = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR_RD,
		ST_CLR_CHK,
		ST_RND_RD,
		ST_RND_CHK,
		ST_RND_DISP,
		ST_RND_FIN
	} state_t;

	localparam logic [15:0] LATE_WINDOW_RST = 16'd1024;

	localparam logic [2:0] REG_PLAYING = 3'd0;
	localparam logic [2:0] REG_LATE    = 3'd4;
endpackage

// ----- hdl/timed_event_block_splitter_top.sv -----
// Timed event block splitter: per-track event FIFOs in one synchronous memory.
// Depends on tebs_pkg.
//
//  channel   handshake             payload
//  request   start / busy          action track frame event_payload num_frames
//  result    strobe (no stall)     kind out_track offset length out_payload accepted
//                                  free_count last
//  config    APB psel/penable      paddr pwdata prdata pready
//
// Append, query, dispatch now, paused render, unknown action, invalid track: busy
// stays low; the result is on the ports in the cycle after the request.
// Clear: busy while it removes tail entries, a read and a check each, until the
// queue empties or an entry before the given frame stops it. Render: a read and a
// check per event, a dispatch per sent event and a final state; the single memory
// read port sets the pace. The final result follows the last busy cycle. Reset
// clears queue heads, counts, play position, rendered mask; memory stays undefined.
// Results leave at most one per cycle on strobe; the receiver cannot stall.
`timescale 1ns / 1ps
module timed_event_block_splitter_top #(
	parameter int NUM_TRACKS = 4,
	parameter int QUEUE_DEPTH = 256,
	parameter int MAX_EVENTS_PER_BLOCK = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [1:0]  track,
	input  logic [31:0] frame,
	input  logic [31:0] event_payload,
	input  logic [12:0] num_frames,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [1:0]  out_track,
	output logic [12:0] offset,
	output logic [12:0] length,
	output logic [31:0] out_payload,
	output logic        accepted,
	output logic [8:0]  free_count,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = PW + 1;
	localparam int AW = TW + PW;
	localparam int SW = 5;

	tebs_pkg::state_t state_q, state_d;

	logic              playing_q;
	logic [15:0]       late_q;
	logic [PW-1:0]     head_q  [NUM_TRACKS];
	logic [CW-1:0]     count_q [NUM_TRACKS];
	logic [31:0]       pos_q;
	logic [NUM_TRACKS-1:0] mask_q;

	logic [63:0]       mem [2**AW];
	logic [63:0]       rd_q;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic              re;

	logic [TW-1:0]     trk_q;
	logic [31:0]       frm_q;
	logic [12:0]       nf_q;
	logic [12:0]       lastoff_q;
	logic [12:0]       off_q;
	logic [SW-1:0]     sent_q;
	logic [31:0]       start_q;

	logic              tvalid;
	logic [TW-1:0]     tin;
	logic              accept;

	assign pready = 1'b1;
	assign busy = (state_q != tebs_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign tin = TW'(track);
	assign tvalid = ({30'd0, track} < NUM_TRACKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			late_q <= tebs_pkg::LATE_WINDOW_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr == tebs_pkg::REG_PLAYING) playing_q <= pwdata[0];
			else if (paddr == tebs_pkg::REG_LATE) late_q <= pwdata[15:0];
		end
	end

	always_comb begin
		case (paddr)
			tebs_pkg::REG_PLAYING: prdata = {31'd0, playing_q};
			tebs_pkg::REG_LATE:    prdata = {16'd0, late_q};
			default:               prdata = 32'd0;
		endcase
	end

	logic [CW-1:0] cnt_t;
	logic [PW-1:0] head_t;
	assign cnt_t = count_q[trk_q];
	assign head_t = head_q[trk_q];

	// head entry fields
	logic [31:0] ef;
	logic [32:0] ef_late;
	logic        is_early, is_drop;
	logic [32:0] diff;
	logic [12:0] off_c;
	logic        beyond;
	assign ef = rd_q[63:32];
	assign is_early = ef < start_q;
	assign ef_late = {1'b0, ef} + {17'd0, late_q};
	assign is_drop = is_early && (ef_late < {1'b0, start_q});
	assign diff = {1'b0, ef} - {1'b0, start_q};
	assign beyond = !is_early && (diff[31:0] >= {19'd0, nf_q});
	assign off_c = is_early ? 13'd0 : diff[12:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			tebs_pkg::ST_IDLE:
				if (accept && tvalid) begin
					if (action == tebs_pkg::ACT_CLEAR) state_d = tebs_pkg::ST_CLR_RD;
					else if (action == tebs_pkg::ACT_RENDER && playing_q)
						state_d = tebs_pkg::ST_RND_RD;
				end
			tebs_pkg::ST_CLR_RD:
				state_d = (cnt_t == '0) ? tebs_pkg::ST_IDLE : tebs_pkg::ST_CLR_CHK;
			tebs_pkg::ST_CLR_CHK:
				state_d = (rd_q[63:32] < frm_q) ? tebs_pkg::ST_IDLE : tebs_pkg::ST_CLR_RD;
			tebs_pkg::ST_RND_RD:
				state_d = (cnt_t == '0 || {27'd0, sent_q} >= MAX_EVENTS_PER_BLOCK) ?
					tebs_pkg::ST_RND_FIN : tebs_pkg::ST_RND_CHK;
			tebs_pkg::ST_RND_CHK:
				if (is_drop) state_d = tebs_pkg::ST_RND_RD;
				else if (beyond || off_c >= nf_q) state_d = tebs_pkg::ST_RND_FIN;
				else state_d = tebs_pkg::ST_RND_DISP;
			tebs_pkg::ST_RND_DISP: state_d = tebs_pkg::ST_RND_RD;
			tebs_pkg::ST_RND_FIN:  state_d = tebs_pkg::ST_IDLE;
			default: state_d = tebs_pkg::ST_IDLE;
		endcase
	end

	// memory addressing
	always_comb begin
		we = 1'b0;
		waddr = {tin, PW'(head_q[tin] + count_q[tin][PW-1:0])};
		re = 1'b0;
		raddr = {trk_q, head_t};
		if (state_q == tebs_pkg::ST_IDLE && accept && tvalid &&
		    action == tebs_pkg::ACT_APPEND && count_q[tin] < CW'(QUEUE_DEPTH))
			we = 1'b1;
		if (state_q == tebs_pkg::ST_CLR_RD) begin
			re = 1'b1;
			raddr = {trk_q, PW'(head_t + cnt_t[PW-1:0] - PW'(1))};
		end else if (state_q == tebs_pkg::ST_RND_RD) begin
			re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= {frame, event_payload};
		if (re) rd_q <= mem[raddr];
	end

	logic [12:0] off_eff;
	assign off_eff = (off_c < lastoff_q) ? lastoff_q : off_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tebs_pkg::ST_IDLE;
			for (int i = 0; i < NUM_TRACKS; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
			pos_q <= '0;
			mask_q <= '0;
			strobe <= 1'b0;
			trk_q <= '0;
			sent_q <= '0;
			lastoff_q <= '0;
			frm_q <= '0;
			nf_q <= '0;
			start_q <= '0;
			off_q <= '0;
			kind <= '0;
			out_track <= '0;
			offset <= '0;
			length <= '0;
			out_payload <= '0;
			accepted <= 1'b0;
			free_count <= '0;
			last <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= 1'b0;
			case (state_q)
				tebs_pkg::ST_IDLE:
					if (accept) begin
						trk_q <= tin;
						frm_q <= frame;
						nf_q <= num_frames;
						start_q <= pos_q;
						sent_q <= '0;
						lastoff_q <= '0;
						kind <= tebs_pkg::KIND_DONE;
						out_track <= track;
						offset <= '0;
						length <= '0;
						out_payload <= '0;
						accepted <= 1'b0;
						free_count <= '0;
						last <= 1'b1;
						strobe <= 1'b1;
						if (action == tebs_pkg::ACT_APPEND) begin
							kind <= tebs_pkg::KIND_REPLY;
							if (tvalid) begin
								if (we) begin
									count_q[tin] <= count_q[tin] + CW'(1);
									accepted <= 1'b1;
								end
								free_count <= 9'(CW'(QUEUE_DEPTH) - count_q[tin] -
									(we ? CW'(1) : CW'(0)));
							end
						end else if (action == tebs_pkg::ACT_QUERY) begin
							kind <= tebs_pkg::KIND_REPLY;
							if (tvalid) free_count <= 9'(CW'(QUEUE_DEPTH) - count_q[tin]);
						end else if (action == tebs_pkg::ACT_NOW && tvalid) begin
							kind <= tebs_pkg::KIND_DISP;
							out_payload <= event_payload;
						end else if (tvalid && (action == tebs_pkg::ACT_CLEAR ||
							(action == tebs_pkg::ACT_RENDER && playing_q))) begin
							strobe <= 1'b0;
						end
					end
				tebs_pkg::ST_CLR_RD:
					if (cnt_t == '0) begin
						kind <= tebs_pkg::KIND_DONE;
						offset <= '0; length <= '0; out_payload <= '0;
						accepted <= 1'b0; free_count <= '0; last <= 1'b1;
						out_track <= 2'(trk_q);
						strobe <= 1'b1;
					end
				tebs_pkg::ST_CLR_CHK:
					if (rd_q[63:32] < frm_q) begin
						kind <= tebs_pkg::KIND_DONE;
						offset <= '0; length <= '0; out_payload <= '0;
						accepted <= 1'b0; free_count <= '0; last <= 1'b1;
						out_track <= 2'(trk_q);
						strobe <= 1'b1;
					end else begin
						count_q[trk_q] <= cnt_t - CW'(1);
					end
				tebs_pkg::ST_RND_CHK:
					if (is_drop) begin
						head_q[trk_q] <= head_t + PW'(1);
						count_q[trk_q] <= cnt_t - CW'(1);
					end else if (!(beyond || off_c >= nf_q)) begin
						kind <= tebs_pkg::KIND_SEG;
						out_track <= 2'(trk_q);
						offset <= lastoff_q;
						length <= off_eff - lastoff_q;
						out_payload <= '0; accepted <= 1'b0; free_count <= '0;
						last <= 1'b0;
						strobe <= 1'b1;
						off_q <= off_eff;
						head_q[trk_q] <= head_t + PW'(1);
						count_q[trk_q] <= cnt_t - CW'(1);
						sent_q <= sent_q + SW'(1);
					end
				tebs_pkg::ST_RND_DISP: begin
					kind <= tebs_pkg::KIND_DISP;
					offset <= off_q;
					length <= '0;
					out_payload <= rd_q[31:0];
					strobe <= 1'b1;
					lastoff_q <= off_q;
				end
				tebs_pkg::ST_RND_FIN: begin
					kind <= tebs_pkg::KIND_SEG;
					out_track <= 2'(trk_q);
					offset <= lastoff_q;
					length <= nf_q - lastoff_q;
					out_payload <= '0; accepted <= 1'b0; free_count <= '0;
					last <= 1'b1;
					strobe <= 1'b1;
					if ((mask_q | (NUM_TRACKS'(1) << trk_q)) == {NUM_TRACKS{1'b1}}) begin
						pos_q <= start_q + {19'd0, nf_q};
						mask_q <= '0;
					end else begin
						mask_q <= mask_q | (NUM_TRACKS'(1) << trk_q);
					end
				end
				default: ;
			endcase
		end
	end
endmodule
